/* sv/ow_pkg.sv */
// ============================================================================
// ow_pkg: shared types and constants of the one-wire bus master
// Command codes, register indexes, field widths and the structs that carry
// configuration and result fields between modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ow_pkg;

   // Field widths fixed by the item format
   localparam int CMD_W      = 2;
   localparam int BYTE_W     = 8;
   localparam int CFG_DATA_W = 10;
   localparam int CFG_ADDR_W = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   // Register indexes
   localparam logic [CFG_ADDR_W-1:0] REG_RESET_LOW    = 3'd0;
   localparam logic [CFG_ADDR_W-1:0] REG_PRESENCE     = 3'd1;
   localparam logic [CFG_ADDR_W-1:0] REG_RECOVER      = 3'd2;
   localparam logic [CFG_ADDR_W-1:0] REG_SLOT_START   = 3'd3;
   localparam logic [CFG_ADDR_W-1:0] REG_READ_SETTLE  = 3'd4;
   localparam logic [CFG_ADDR_W-1:0] REG_SLOT_HOLD    = 3'd5;

   // Register reset values
   localparam logic [9:0] RESET_LOW_DEF   = 10'd500;
   localparam logic [9:0] PRESENCE_DEF    = 10'd68;
   localparam logic [9:0] RECOVER_DEF     = 10'd500;
   localparam logic [5:0] SLOT_START_DEF  = 6'd2;
   localparam logic [5:0] READ_SETTLE_DEF = 6'd2;
   localparam logic [7:0] SLOT_HOLD_DEF   = 8'd60;

   // Timing configuration
   typedef struct packed {
      logic [9:0] reset_low_ticks;
      logic [9:0] presence_wait_ticks;
      logic [9:0] reset_recover_ticks;
      logic [5:0] slot_start_ticks;
      logic [5:0] read_settle_ticks;
      logic [7:0] slot_hold_ticks;
   } ow_cfg_type;

   // One result item
   typedef struct packed {
      logic              line_release;
      logic              busy_res;
      logic              done_res;
      logic              device_present;
      logic [BYTE_W-1:0] read_data;
   } ow_result_type;

endpackage

`default_nettype wire

/* sv/one_wire_bus_master_unit.sv */
// ============================================================================
// one_wire_bus_master_unit: one-wire bus master
// Takes one tick item per bus microsecond and returns the line drive and
// status for that tick.
// ============================================================================
//  channel | ports          | payload
//  --------+----------------+-------------------------------------------
//  input   | req_t*         | tuser: cmd; tdata: data_byte, line_in
//  result  | rsp_t*         | tdata: line_release .. read_data
//  config  | csr_*          | index 0..5, 10-bit write data
//
//  Every accepted item gives one result item in the next cycle; one item per
//  cycle is sustained while results are taken, set by the single result register.
//  The input is taken whenever the result register is empty or being taken.
//  Reset is synchronous; it restores timing registers and an idle released
//  line. A stalled result holds; the input then stalls until it is taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master_unit #(
   parameter int TICK_COUNT_BITS = 10
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input item
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // [7:0] data_byte, [8] line_in, [15:9] zero
   input  wire logic [ow_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] cmd
   input  wire logic [ow_pkg::CMD_W-1:0]        req_tuser,
   // result item
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] line_release, [1] busy_res, [2] done_res, [3] device_present,
   // [11:4] read_data, [15:12] zero
   output      logic [ow_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration write
   input  wire logic                            csr_wen,
   input  wire logic [ow_pkg::CFG_ADDR_W-1:0]   csr_addr,
   input  wire logic [ow_pkg::CFG_DATA_W-1:0]   csr_wdata
);

   ow_pkg::ow_cfg_type    cfg;
   ow_pkg::ow_result_type result;
   ow_pkg::ow_result_type rsp_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ow_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ow_core #(
      .TICK_COUNT_BITS (TICK_COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .cmd        (req_tuser),
      .data_byte  (req_tdata[7:0]),
      .line_in    (req_tdata[8]),
      .cfg        (cfg),
      .result     (result)
   );

   // Result register valid: set on accept, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result payload on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff.read_data, rsp_data_ff.device_present,
                        rsp_data_ff.done_res, rsp_data_ff.busy_res,
                        rsp_data_ff.line_release};

endmodule

`default_nettype wire

/* sv/ow_cfg.sv */
// ============================================================================
// ow_cfg: timing register file
// Six write-only timing registers loaded from the plain write port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ow_cfg (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wen,
   input  wire logic [ow_pkg::CFG_ADDR_W-1:0]   csr_addr,
   input  wire logic [ow_pkg::CFG_DATA_W-1:0]   csr_wdata,
   output ow_pkg::ow_cfg_type                   cfg
);

   ow_pkg::ow_cfg_type cfg_ff;
   ow_pkg::ow_cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            ow_pkg::REG_RESET_LOW:   cfg_in.reset_low_ticks     = csr_wdata;
            ow_pkg::REG_PRESENCE:    cfg_in.presence_wait_ticks = csr_wdata;
            ow_pkg::REG_RECOVER:     cfg_in.reset_recover_ticks = csr_wdata;
            ow_pkg::REG_SLOT_START:  cfg_in.slot_start_ticks    = csr_wdata[5:0];
            ow_pkg::REG_READ_SETTLE: cfg_in.read_settle_ticks   = csr_wdata[5:0];
            ow_pkg::REG_SLOT_HOLD:   cfg_in.slot_hold_ticks     = csr_wdata[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks     <= ow_pkg::RESET_LOW_DEF;
         cfg_ff.presence_wait_ticks <= ow_pkg::PRESENCE_DEF;
         cfg_ff.reset_recover_ticks <= ow_pkg::RECOVER_DEF;
         cfg_ff.slot_start_ticks    <= ow_pkg::SLOT_START_DEF;
         cfg_ff.read_settle_ticks   <= ow_pkg::READ_SETTLE_DEF;
         cfg_ff.slot_hold_ticks     <= ow_pkg::SLOT_HOLD_DEF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* sv/ow_core.sv */
// ============================================================================
// ow_core: bus sequencer
// Phase machine advanced once per accepted tick item; emits the result of
// that tick combinationally from the next state.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ow_core #(
   parameter int TICK_COUNT_BITS = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_valid,
   input  wire logic [ow_pkg::CMD_W-1:0]      cmd,
   input  wire logic [ow_pkg::BYTE_W-1:0]     data_byte,
   input  wire logic                          line_in,
   input  ow_pkg::ow_cfg_type                 cfg,
   output ow_pkg::ow_result_type              result
);

   localparam int CMP_W = (TICK_COUNT_BITS > 10) ? TICK_COUNT_BITS : 10;
   localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = {TICK_COUNT_BITS{1'b1}};
   localparam logic [TICK_COUNT_BITS-1:0] CNT_ONE = TICK_COUNT_BITS'(1);

   typedef enum logic [2:0] {
      PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
      PH_SLOT_LOW, PH_SETTLE, PH_HOLD, PH_GAP
   } phase_type;

   phase_type                  phase_ff,  phase_in;
   logic [ow_pkg::CMD_W-1:0]   op_ff,     op_in;
   logic [TICK_COUNT_BITS-1:0] tick_ff,   tick_in;
   logic [2:0]                 bit_ff,    bit_in;
   logic [ow_pkg::BYTE_W-1:0]  shift_ff,  shift_in;
   logic                       pres_ff,   pres_in;
   logic                       line_ff,   line_in_nx;
   logic [ow_pkg::BYTE_W-1:0]  rdbyte_ff, rdbyte_in;

   logic [9:0] limit;
   logic       over;
   logic       done;

   // Select the length of the current phase
   always_comb begin
      case (phase_ff)
         PH_RST_LOW:  limit = cfg.reset_low_ticks;
         PH_RST_WAIT: limit = cfg.presence_wait_ticks;
         PH_RST_REC:  limit = cfg.reset_recover_ticks;
         PH_SLOT_LOW: limit = {4'b0, cfg.slot_start_ticks};
         PH_SETTLE:   limit = {4'b0, cfg.read_settle_ticks};
         PH_HOLD:     limit = {2'b0, cfg.slot_hold_ticks};
         PH_GAP:      limit = 10'd1;
         default:     limit = 10'd0;
      endcase
   end

   // Phase ends at its length or when the counter saturates
   assign over = (CMP_W'(tick_ff) >= CMP_W'(limit)) || (tick_ff == CNT_MAX);

   // Advance the sequencer by one tick
   always_comb begin
      phase_in   = phase_ff;
      op_in      = op_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      pres_in    = pres_ff;
      line_in_nx = line_ff;
      rdbyte_in  = rdbyte_ff;
      done       = 1'b0;
      if (phase_ff != PH_IDLE && !over) begin
         tick_in = tick_ff + CNT_ONE;
      end
      case (phase_ff)
         PH_IDLE: begin
            if (cmd == ow_pkg::CMD_RESET) begin
               op_in      = ow_pkg::CMD_RESET;
               phase_in   = PH_RST_LOW;
               tick_in    = CNT_ONE;
               line_in_nx = 1'b0;
            end else if (cmd == ow_pkg::CMD_WRITE || cmd == ow_pkg::CMD_READ) begin
               op_in  = cmd;
               bit_in = 3'd0;
               if (cmd == ow_pkg::CMD_WRITE) begin
                  shift_in = data_byte;
               end
               phase_in   = PH_SLOT_LOW;
               tick_in    = CNT_ONE;
               line_in_nx = 1'b0;
            end
         end
         PH_RST_LOW: begin
            if (over) begin
               phase_in   = PH_RST_WAIT;
               tick_in    = CNT_ONE;
               line_in_nx = 1'b1;
            end
         end
         PH_RST_WAIT: begin
            if (over) begin
               pres_in    = ~line_in;
               phase_in   = PH_RST_REC;
               tick_in    = CNT_ONE;
               line_in_nx = 1'b1;
            end
         end
         PH_RST_REC: begin
            if (over) begin
               phase_in   = PH_IDLE;
               tick_in    = '0;
               line_in_nx = 1'b1;
               done       = 1'b1;
            end
         end
         PH_SLOT_LOW: begin
            if (over) begin
               tick_in = CNT_ONE;
               if (op_ff == ow_pkg::CMD_READ) begin
                  phase_in   = PH_SETTLE;
                  line_in_nx = 1'b1;
               end else begin
                  phase_in   = PH_HOLD;
                  line_in_nx = shift_ff[bit_ff];
               end
            end
         end
         PH_SETTLE: begin
            if (over) begin
               shift_in[bit_ff] = line_in;
               phase_in         = PH_HOLD;
               tick_in          = CNT_ONE;
               line_in_nx       = 1'b1;
            end
         end
         PH_HOLD: begin
            if (over) begin
               if (bit_ff == 3'd7) begin
                  if (op_ff == ow_pkg::CMD_READ) begin
                     rdbyte_in = shift_ff;
                  end
                  phase_in   = PH_IDLE;
                  tick_in    = '0;
                  line_in_nx = 1'b1;
                  done       = 1'b1;
               end else begin
                  bit_in     = bit_ff + 3'd1;
                  phase_in   = PH_GAP;
                  tick_in    = CNT_ONE;
                  line_in_nx = 1'b1;
               end
            end
         end
         PH_GAP: begin
            if (over) begin
               phase_in   = PH_SLOT_LOW;
               tick_in    = CNT_ONE;
               line_in_nx = 1'b0;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // Hold state; advance only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         op_ff     <= ow_pkg::CMD_TICK;
         tick_ff   <= '0;
         bit_ff    <= '0;
         shift_ff  <= '0;
         pres_ff   <= 1'b0;
         line_ff   <= 1'b1;
         rdbyte_ff <= '0;
      end else if (item_valid) begin
         phase_ff  <= phase_in;
         op_ff     <= op_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         pres_ff   <= pres_in;
         line_ff   <= line_in_nx;
         rdbyte_ff <= rdbyte_in;
      end
   end

   // Result of this tick
   assign result.line_release   = line_in_nx;
   assign result.busy_res       = (phase_in != PH_IDLE);
   assign result.done_res       = done;
   assign result.device_present = pres_in;
   assign result.read_data      = rdbyte_in;

endmodule

`default_nettype wire

/* sv/ow_checker.sv */
// ============================================================================
// ow_checker: port-level checks of the one-wire bus master
// Watches the item channels of the top level and flags ordering or status
// slips.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ow_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ow_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   // Each accepted item shows a result next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");

   // Input is open whenever no result is pending
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // Done ends an operation, so busy is low on that item
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1])
      else $error("done reported while still busy");

   // Idle master leaves the line released
   a_idle_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[0])
      else $error("line pulled low while idle");

endmodule

bind one_wire_bus_master_unit ow_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* tb/one_wire_bus_master_unit_checker.sv */
// ============================================================================
// one_wire_bus_master_unit_checker: result checker for the one-wire master
// Watches the tick, result and register channels. It keeps its own copy of
// the bus sequencer and of the timing registers, predicts the status item of
// every accepted tick and compares each result item with the oldest
// prediction. It hands out its failure count and the number of predictions
// still waiting.
// ============================================================================
`timescale 1ns / 1ps

module one_wire_bus_master_unit_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   // [7:0] data_byte, [8] line_in, [15:9] zero
   input  wire logic [ow_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] cmd
   input  wire logic [ow_pkg::CMD_W-1:0]        req_tuser,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] line_release, [1] busy_res, [2] done_res, [3] device_present,
   // [11:4] read_data, [15:12] zero
   input  wire logic [ow_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                            csr_wen,
   input  wire logic [ow_pkg::CFG_ADDR_W-1:0]   csr_addr,
   input  wire logic [ow_pkg::CFG_DATA_W-1:0]   csr_wdata,
   output int                                   fail_count,
   output int                                   pending_count
);

   import ow_pkg::*;

   localparam int TICK_W = 10;
   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   typedef enum logic [2:0] {
      BUS_IDLE,
      BUS_RESET_LOW,
      BUS_PRESENCE_WAIT,
      BUS_RECOVER,
      BUS_SLOT_LOW,
      BUS_READ_SETTLE,
      BUS_SLOT_HOLD,
      BUS_SLOT_GAP
   } bus_phase_e;

   // Shadow timing registers and sequencer state
   ow_cfg_type          cfg;
   bus_phase_e          phase_q;
   logic [CMD_W-1:0]    op_q;
   logic [TICK_W-1:0]   ticks_q;
   logic [2:0]          bit_q;
   logic [BYTE_W-1:0]   shift_q;
   logic                present_q;
   logic                drive_q;
   logic [BYTE_W-1:0]   read_q;

   // Predicted status items, oldest first
   ow_result_type       bus_status_q[$];
   int                  errors = 0;

   // Start a phase: its entry tick is the first one counted
   function automatic void enter_phase(input bus_phase_e ph, input logic level);
      phase_q = ph;
      ticks_q = TICK_W'(1);
      drive_q = level;
   endfunction

   // True on the tick that ends a window of len ticks; zero acts as one
   function automatic logic window_over(input logic [TICK_W-1:0] len);
      if (ticks_q >= len || ticks_q == TICK_MAX) return 1'b1;
      ticks_q = ticks_q + 1'b1;
      return 1'b0;
   endfunction

   // Advance the sequencer by one tick and return the status it shows
   function automatic ow_result_type step_bus(input logic [CMD_W-1:0] cmd,
                                              input logic [BYTE_W-1:0] data,
                                              input logic line);
      ow_result_type r;
      logic          done;
      done = 1'b0;
      case (phase_q)
         BUS_IDLE: begin
            if (cmd == CMD_RESET) begin
               op_q = CMD_RESET;
               enter_phase(BUS_RESET_LOW, 1'b0);
            end else if (cmd == CMD_WRITE || cmd == CMD_READ) begin
               op_q  = cmd;
               bit_q = '0;
               if (cmd == CMD_WRITE) shift_q = data;
               enter_phase(BUS_SLOT_LOW, 1'b0);
            end
         end
         BUS_RESET_LOW: begin
            if (window_over(cfg.reset_low_ticks)) enter_phase(BUS_PRESENCE_WAIT, 1'b1);
         end
         BUS_PRESENCE_WAIT: begin
            // a device answers by holding the line low at the sample
            if (window_over(cfg.presence_wait_ticks)) begin
               present_q = ~line;
               enter_phase(BUS_RECOVER, 1'b1);
            end
         end
         BUS_RECOVER: begin
            if (window_over(cfg.reset_recover_ticks)) begin
               phase_q = BUS_IDLE;
               ticks_q = '0;
               drive_q = 1'b1;
               done    = 1'b1;
            end
         end
         BUS_SLOT_LOW: begin
            if (window_over(TICK_W'(cfg.slot_start_ticks))) begin
               if (op_q == CMD_READ) enter_phase(BUS_READ_SETTLE, 1'b1);
               else enter_phase(BUS_SLOT_HOLD, shift_q[bit_q]);
            end
         end
         BUS_READ_SETTLE: begin
            if (window_over(TICK_W'(cfg.read_settle_ticks))) begin
               shift_q[bit_q] = line;
               enter_phase(BUS_SLOT_HOLD, 1'b1);
            end
         end
         BUS_SLOT_HOLD: begin
            if (window_over(TICK_W'(cfg.slot_hold_ticks))) begin
               if (bit_q == 3'd7) begin
                  if (op_q == CMD_READ) read_q = shift_q;
                  phase_q = BUS_IDLE;
                  ticks_q = '0;
                  drive_q = 1'b1;
                  done    = 1'b1;
               end else begin
                  bit_q = bit_q + 1'b1;
                  enter_phase(BUS_SLOT_GAP, 1'b1);
               end
            end
         end
         default: begin
            // one released tick between slots
            if (window_over(TICK_W'(1))) enter_phase(BUS_SLOT_LOW, 1'b0);
         end
      endcase
      r.line_release   = drive_q;
      r.busy_res       = (phase_q != BUS_IDLE);
      r.done_res       = done;
      r.device_present = present_q;
      r.read_data      = read_q;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         errors++;
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      ow_result_type want;
      if (reset) begin
         cfg.reset_low_ticks     = RESET_LOW_DEF;
         cfg.presence_wait_ticks = PRESENCE_DEF;
         cfg.reset_recover_ticks = RECOVER_DEF;
         cfg.slot_start_ticks    = SLOT_START_DEF;
         cfg.read_settle_ticks   = READ_SETTLE_DEF;
         cfg.slot_hold_ticks     = SLOT_HOLD_DEF;
         phase_q   = BUS_IDLE;
         op_q      = CMD_TICK;
         ticks_q   = '0;
         bit_q     = '0;
         shift_q   = '0;
         present_q = 1'b0;
         drive_q   = 1'b1;
         read_q    = '0;
         bus_status_q.delete();
      end else begin
         // compare a taken result item with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (bus_status_q.size() == 0) begin
               errors++;
               $error("result item 0x%0h with no prediction waiting", rsp_tdata);
            end else begin
               want = bus_status_q.pop_front();
               check_field("line_release", 32'(want.line_release), 32'(rsp_tdata[0]));
               check_field("busy_res", 32'(want.busy_res), 32'(rsp_tdata[1]));
               check_field("done_res", 32'(want.done_res), 32'(rsp_tdata[2]));
               check_field("device_present", 32'(want.device_present),
                           32'(rsp_tdata[3]));
               check_field("read_data", 32'(want.read_data), 32'(rsp_tdata[11:4]));
               check_field("rsp_tdata[15:12]", 0, 32'(rsp_tdata[15:12]));
            end
         end
         // follow register writes
         if (csr_wen) begin
            case (csr_addr)
               REG_RESET_LOW:   cfg.reset_low_ticks     = csr_wdata;
               REG_PRESENCE:    cfg.presence_wait_ticks = csr_wdata;
               REG_RECOVER:     cfg.reset_recover_ticks = csr_wdata;
               REG_SLOT_START:  cfg.slot_start_ticks    = csr_wdata[5:0];
               REG_READ_SETTLE: cfg.read_settle_ticks   = csr_wdata[5:0];
               REG_SLOT_HOLD:   cfg.slot_hold_ticks     = csr_wdata[7:0];
               default: ;
            endcase
         end
         // predict the status of an accepted tick
         if (req_tvalid && req_tready)
            bus_status_q.push_back(step_bus(req_tuser, req_tdata[7:0], req_tdata[8]));
      end
      pending_count <= bus_status_q.size();
      fail_count    <= errors;
   end

endmodule

/* tb/one_wire_bus_master_unit_tb.sv */
// ============================================================================
// one_wire_bus_master_unit_tb: testbench of the one-wire bus master
// Feeds tick items that carry reset, write and read commands with random
// line levels, under timing settings from all-zero through all-one to
// random small ones. Both channels idle at random and the result side holds
// off for a long stretch. A checker beside the block predicts every status
// item.
// ============================================================================
`timescale 1ns / 1ps

module one_wire_bus_master_unit_tb;

   import ow_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int RANDOM_ITEMS = 700;
   localparam int LONG_HOLD    = 300;
   localparam int END_CYCLES   = 8;

   // line_in patterns during an operation
   localparam int LINE_LOW  = 0;
   localparam int LINE_HIGH = 1;
   localparam int LINE_RAND = 2;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [CMD_W-1:0]        req_tuser  = CMD_TICK;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_wen    = 1'b0;
   logic [CFG_ADDR_W-1:0]   csr_addr   = REG_RESET_LOW;
   logic [CFG_DATA_W-1:0]   csr_wdata  = '0;

   int                      fail_count;
   int                      pending_count;
   int                      cycles     = 0;
   int                      items_sent = 0;
   int                      rsp_taken  = 0;
   bit                      tx_steady  = 1'b0;
   bit                      rx_steady  = 1'b0;
   ow_cfg_type              cur_cfg;

   one_wire_bus_master_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   one_wire_bus_master_unit_checker status_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wen       (csr_wen),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #CLK_HALF clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Idle length: mostly none, some short, a few long
   function automatic int idle_len(input bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 75) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int at_least_one(input int v);
      return (v == 0) ? 1 : v;
   endfunction

   // Ticks an operation keeps the sequencer busy, command tick included
   function automatic int op_span(input logic [CMD_W-1:0] op);
      int ss;
      int hold;
      ss   = at_least_one(cur_cfg.slot_start_ticks);
      hold = at_least_one(cur_cfg.slot_hold_ticks);
      case (op)
         CMD_RESET: return at_least_one(cur_cfg.reset_low_ticks)
                          + at_least_one(cur_cfg.presence_wait_ticks)
                          + at_least_one(cur_cfg.reset_recover_ticks);
         CMD_WRITE: return 8 * (ss + hold) + 7;
         CMD_READ:  return 8 * (ss + at_least_one(cur_cfg.read_settle_ticks) + hold) + 7;
         default:   return 1;
      endcase
   endfunction

   function automatic int longest_span();
      int a;
      int b;
      a = op_span(CMD_RESET);
      b = op_span(CMD_READ);
      return ((a > b) ? a : b) + 2;
   endfunction

   function automatic logic pick_line(input int mode);
      if (mode == LINE_LOW) return 1'b0;
      if (mode == LINE_HIGH) return 1'b1;
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // Mostly plain ticks, now and then a command the busy block must ignore
   function automatic logic [CMD_W-1:0] busy_cmd();
      logic [CMD_W-1:0] c;
      c = CMD_TICK;
      if ($urandom_range(0, 6) == 0) c = CMD_W'($urandom_range(0, 3));
      return c;
   endfunction

   // Offer one tick item and wait until it is taken
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] byte_val,
                            input logic line);
      int gap;
      if (items_sent % 64 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      gap = idle_len(tx_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, line, byte_val};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Issue a command, then tick through it; slack moves the next command
   // earlier (into the busy time or onto the done tick) or later
   task automatic run_op(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] byte_val,
                         input int line_mode, input int slack);
      int busy;
      int span;
      int k;
      busy = op_span(op) - 1;
      span = busy + slack;
      send_item(op, byte_val, pick_line(line_mode));
      for (k = 0; k < span; k++)
         send_item((k < busy) ? busy_cmd() : CMD_TICK, rand_byte(),
                   pick_line(line_mode));
   endtask

   task automatic random_op();
      int r;
      int slack;
      logic [CMD_W-1:0] op;
      r = $urandom_range(0, 9);
      if (r < 3) op = CMD_RESET;
      else if (r < 6) op = CMD_WRITE;
      else if (r < 9) op = CMD_READ;
      else op = CMD_TICK;
      r = $urandom_range(0, 9);
      if (op == CMD_TICK) slack = $urandom_range(0, 5);
      else if (r < 6) slack = 0;
      else if (r == 6) slack = -1;
      else if (r == 7) begin
         slack = $urandom_range(2, 4);
         slack = -slack;
      end else slack = $urandom_range(1, 3);
      run_op(op, rand_byte(), LINE_RAND, slack);
   endtask

   // Let any operation finish, then stop and wait for every result
   task automatic settle_bus(input int drain);
      repeat (drain) send_item(CMD_TICK, rand_byte(), pick_line(LINE_RAND));
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Write all six timing registers, one per cycle
   task automatic load_cfg(input ow_cfg_type c);
      logic [CFG_ADDR_W-1:0] idx [0:5];
      logic [CFG_DATA_W-1:0] val [0:5];
      int i;
      cur_cfg = c;
      idx[0] = REG_RESET_LOW;   val[0] = c.reset_low_ticks;
      idx[1] = REG_PRESENCE;    val[1] = c.presence_wait_ticks;
      idx[2] = REG_RECOVER;     val[2] = c.reset_recover_ticks;
      idx[3] = REG_SLOT_START;  val[3] = CFG_DATA_W'(c.slot_start_ticks);
      idx[4] = REG_READ_SETTLE; val[4] = CFG_DATA_W'(c.read_settle_ticks);
      idx[5] = REG_SLOT_HOLD;   val[5] = CFG_DATA_W'(c.slot_hold_ticks);
      for (i = 0; i < 6; i++) begin
         csr_wen   <= 1'b1;
         csr_addr  <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_wen <= 1'b0;
   endtask

   function automatic ow_cfg_type random_cfg();
      ow_cfg_type c;
      int reach;
      reach = ($urandom_range(0, 3) == 0) ? 40 : 10;
      c.reset_low_ticks     = 10'($urandom_range(0, reach));
      c.presence_wait_ticks = 10'($urandom_range(0, reach));
      c.reset_recover_ticks = 10'($urandom_range(0, reach));
      c.slot_start_ticks    = 6'($urandom_range(0, 4));
      c.read_settle_ticks   = 6'($urandom_range(0, 4));
      c.slot_hold_ticks     = 8'($urandom_range(0, 10));
      return c;
   endfunction

   // Result side: random stalls, with a long hold-off now and then
   initial begin : receiver
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_taken % 50 == 0) rx_steady = ($urandom_range(0, 3) == 0);
         gap = idle_len(rx_steady);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_taken++;
         // hold off so the result register fills and ticks back up
         if (rsp_taken % 2000 == 700) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      ow_cfg_type c;
      int base;
      int n_ops;
      int k;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      cur_cfg.reset_low_ticks     = RESET_LOW_DEF;
      cur_cfg.presence_wait_ticks = PRESENCE_DEF;
      cur_cfg.reset_recover_ticks = RECOVER_DEF;
      cur_cfg.slot_start_ticks    = SLOT_START_DEF;
      cur_cfg.read_settle_ticks   = READ_SETTLE_DEF;
      cur_cfg.slot_hold_ticks     = SLOT_HOLD_DEF;

      // power-on timing: a bare tick and one byte write
      run_op(CMD_TICK, 8'h00, LINE_HIGH, 0);
      run_op(CMD_WRITE, 8'hA5, LINE_RAND, 0);
      settle_bus(2);

      // every timing register zero, which acts as one tick
      c = '0;
      load_cfg(c);
      run_op(CMD_RESET, 8'h00, LINE_LOW, 0);
      run_op(CMD_RESET, 8'hFF, LINE_HIGH, 0);
      run_op(CMD_WRITE, 8'hFF, LINE_HIGH, 0);
      run_op(CMD_WRITE, 8'h00, LINE_LOW, 0);
      run_op(CMD_READ, 8'h00, LINE_HIGH, -1);
      // a command on the last busy tick is dropped
      send_item(CMD_WRITE, 8'h81, 1'b1);
      run_op(CMD_READ, 8'hFF, LINE_LOW, 0);
      settle_bus(2);

      // every timing register one; a command in mid-write is dropped
      c = '0;
      c.reset_low_ticks     = 10'd1;
      c.presence_wait_ticks = 10'd1;
      c.reset_recover_ticks = 10'd1;
      c.slot_start_ticks    = 6'd1;
      c.read_settle_ticks   = 6'd1;
      c.slot_hold_ticks     = 8'd1;
      load_cfg(c);
      run_op(CMD_RESET, 8'h5A, LINE_RAND, 0);
      run_op(CMD_WRITE, 8'h3C, LINE_RAND, -4);
      run_op(CMD_READ, 8'h00, LINE_RAND, 0);
      settle_bus(longest_span());

      // random operations under random small timings
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         load_cfg(random_cfg());
         n_ops = $urandom_range(4, 10);
         for (k = 0; k < n_ops; k++) random_op();
         settle_bus(longest_span());
      end

      repeat (END_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
